@@ hw/rtl/selt_pkg.sv @@
`timescale 1ns / 1ps

package selt_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 32;
    localparam int MAX_SHARED    = 255;

    // Width of the request key port.
    localparam int KEY_IN_W = 32;

    // Only the low key bits that fit in the port take part in matching.
    localparam int KEY_W  = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_SHARED + 1);
    localparam int HCNT_W = 8;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ACQ_SHARED  = 2'd0,
        REQ_ACQ_EXCL    = 2'd1,
        REQ_REL_SHARED  = 2'd2,
        REQ_REL_EXCL    = 2'd3
    } t_req_type;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_GRANTED  = 3'd0,
        STAT_CONFLICT = 3'd1,
        STAT_LIMIT    = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_RELEASED = 3'd4,
        STAT_IGNORED  = 3'd5
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic apply;
    } t_dp_cmd;

endpackage

@@ hw/rtl/selt_ctrl.sv @@
`timescale 1ns / 1ps

module selt_ctrl
    import selt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: capture, then look up, then apply.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb begin
        busy          = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.lookup  = 1'b0;
        o_cmd.apply   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ST_MATCH: begin
                o_cmd.lookup = 1'b1;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ hw/rtl/selt_datapath.sv @@
`timescale 1ns / 1ps

module selt_datapath
    import selt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [1:0]          i_req_type,
    input  logic [KEY_IN_W-1:0] i_resource_key,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [HCNT_W-1:0]   o_holder_count,
    output logic                o_exclusive_held
);

    // Captured request.
    t_req_type          r_req;
    logic [KEY_W-1:0]   r_key;

    // Lock table entries.
    logic [KEY_W-1:0]   r_entry_key   [TABLE_ENTRIES];
    logic               r_entry_valid [TABLE_ENTRIES];
    logic               r_entry_excl  [TABLE_ENTRIES];
    logic [CNT_W-1:0]   r_entry_cnt   [TABLE_ENTRIES];

    // Registered lookup results.
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_excl;

    // Lookup logic.
    logic               n_hit;
    logic [IDX_W-1:0]   n_hit_idx;
    logic               n_free_ok;
    logic [IDX_W-1:0]   n_free_idx;

    // Update logic.
    logic               n_wr_en;
    logic               n_wr_alloc;
    logic [IDX_W-1:0]   n_wr_idx;
    logic               n_wr_valid;
    logic               n_wr_excl;
    logic [CNT_W-1:0]   n_wr_cnt;
    t_status            n_status;
    logic               n_show;

    // Result registers.
    logic               r_out_valid;
    t_status            r_out_status;
    logic [HCNT_W-1:0]  r_out_cnt;
    logic               r_out_excl;

    // Capture the request word when the controller accepts it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= t_req_type'(i_req_type);
            r_key <= i_resource_key[KEY_W-1:0];
        end
    end

    // Associative match and free search; the lowest index wins in both.
    always_comb begin
        n_hit      = 1'b0;
        n_hit_idx  = '0;
        n_free_ok  = 1'b0;
        n_free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_entry_valid[i] && (r_entry_key[i] == r_key)) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
            if (!r_entry_valid[i]) begin
                n_free_ok  = 1'b1;
                n_free_idx = IDX_W'(i);
            end
        end
    end

    // Register the lookup and the matched entry's state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_free_ok  <= n_free_ok;
            r_free_idx <= n_free_idx;
            r_cnt      <= r_entry_cnt[n_hit_idx];
            r_excl     <= r_entry_excl[n_hit_idx];
        end
    end

    // Decide the outcome and the new state of the touched entry.
    always_comb begin
        n_wr_en    = 1'b0;
        n_wr_alloc = 1'b0;
        n_wr_idx   = r_hit_idx;
        n_wr_valid = r_hit;
        n_wr_excl  = r_excl;
        n_wr_cnt   = r_cnt;
        n_status   = STAT_IGNORED;
        case (r_req) inside
            REQ_ACQ_SHARED, REQ_ACQ_EXCL: begin
                if (!r_hit) begin
                    if (!r_free_ok) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_wr_en    = 1'b1;
                        n_wr_alloc = 1'b1;
                        n_wr_idx   = r_free_idx;
                        n_wr_valid = 1'b1;
                        n_wr_excl  = (r_req == REQ_ACQ_EXCL);
                        n_wr_cnt   = (r_req == REQ_ACQ_SHARED) ? CNT_W'(1) : '0;
                        n_status   = STAT_GRANTED;
                    end
                end else if (r_req == REQ_ACQ_SHARED) begin
                    if (r_excl) begin
                        n_status = STAT_CONFLICT;
                    end else if (r_cnt >= CNT_W'(MAX_SHARED)) begin
                        n_status = STAT_LIMIT;
                    end else begin
                        n_wr_en  = 1'b1;
                        n_wr_cnt = r_cnt + CNT_W'(1);
                        n_status = STAT_GRANTED;
                    end
                end else begin
                    if (r_excl || (r_cnt != '0)) begin
                        n_status = STAT_CONFLICT;
                    end else begin
                        n_wr_en   = 1'b1;
                        n_wr_excl = 1'b1;
                        n_status  = STAT_GRANTED;
                    end
                end
            end
            REQ_REL_SHARED: begin
                if (r_hit && (r_cnt != '0)) begin
                    n_wr_en    = 1'b1;
                    n_wr_cnt   = r_cnt - CNT_W'(1);
                    n_wr_valid = (n_wr_cnt != '0) || r_excl;
                    n_status   = STAT_RELEASED;
                end
            end
            default: begin
                if (r_hit && r_excl) begin
                    n_wr_en    = 1'b1;
                    n_wr_excl  = 1'b0;
                    n_wr_valid = (r_cnt != '0);
                    n_status   = STAT_RELEASED;
                end
            end
        endcase
        // An entry that is gone, or never was, reports no holders.
        n_show = n_wr_valid;
    end

    // Entry valid bits, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_entry_valid[i] <= 1'b0;
            end
        end else if (i_cmd.apply && n_wr_en) begin
            r_entry_valid[n_wr_idx] <= n_wr_valid;
        end
    end

    // Entry payload; a freed entry is cleared for the next owner.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && n_wr_en) begin
            r_entry_excl[n_wr_idx] <= n_wr_valid ? n_wr_excl : 1'b0;
            r_entry_cnt[n_wr_idx]  <= n_wr_valid ? n_wr_cnt : '0;
            if (n_wr_alloc) begin
                r_entry_key[n_wr_idx] <= r_key;
            end
        end
    end

    // Result word, shown for one cycle after the update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out_status <= n_status;
            r_out_cnt    <= n_show ? HCNT_W'(n_wr_cnt) : '0;
            r_out_excl   <= n_show ? n_wr_excl : 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_holder_count   = r_out_cnt;
    assign o_exclusive_held = r_out_excl;

endmodule

@@ hw/rtl/shared_exclusive_lock_table.sv @@
`timescale 1ns / 1ps

// Shared/exclusive lock table. Each request word names a key and acquires it
// shared or exclusive, or releases a shared or exclusive hold, and is answered
// with one result word: a status, the key's shared-holder count and its
// exclusive flag after the request. A request is taken when start is high and
// busy is low; it then passes through capture, associative lookup of the table
// and update, and busy stays high until the update, so a new request is taken
// only after the last one is done. The result appears on the output ports for
// exactly one cycle, marked by o_valid, in the cycle after the update; the
// receiver cannot stall it and must take it then. The table holds 16 entries
// and needs no clearing after reset.

module shared_exclusive_lock_table
    import selt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_req_type,
    input  logic [KEY_IN_W-1:0] i_resource_key,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [HCNT_W-1:0]   o_holder_count,
    output logic                o_exclusive_held
);

    t_dp_cmd cmd;

    // Sequencer for one request at a time.
    selt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Lock table and result registers.
    selt_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req_type       (i_req_type),
        .i_resource_key   (i_resource_key),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_holder_count   (o_holder_count),
        .o_exclusive_held (o_exclusive_held)
    );

endmodule

@@ dv/tb_shared_exclusive_lock_table.sv @@
`timescale 1ns / 1ps

module tb_shared_exclusive_lock_table;
    import selt_pkg::*;

    localparam int IDLE_LIMIT   = 500;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 1150;
    localparam int POOL_KEYS    = 20;

    localparam logic [KEY_IN_W-1:0] KEY_MASK = {KEY_IN_W{1'b1}} >> (KEY_IN_W - KEY_W);

    // One request word and one result word.
    typedef struct {
        t_req_type           req;
        logic [KEY_IN_W-1:0] key;
    } t_lock_req;

    typedef struct {
        t_status         status;
        logic [7:0]      holders;
        logic            excl;
    } t_lock_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_req_type = REQ_ACQ_SHARED;
    logic [KEY_IN_W-1:0] i_resource_key = '0;
    logic                o_valid;
    logic [2:0]          o_status;
    logic [HCNT_W-1:0]   o_holder_count;
    logic                o_exclusive_held;

    t_lock_req    request_q[$];
    t_lock_result grant_q[$];

    // Private copy of the lock table.
    logic [KEY_IN_W-1:0] tbl_key   [TABLE_ENTRIES];
    bit                  tbl_valid [TABLE_ENTRIES];
    bit                  tbl_excl  [TABLE_ENTRIES];
    int unsigned         tbl_count [TABLE_ENTRIES];

    logic [KEY_IN_W-1:0] key_pool [POOL_KEYS];

    int n_mismatch = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    shared_exclusive_lock_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_resource_key   (i_resource_key),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_holder_count   (o_holder_count),
        .o_exclusive_held (o_exclusive_held)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the private table and work out the word it returns.
    task automatic update_lock_table(input t_lock_req rq, output t_lock_result res);
        logic [KEY_IN_W-1:0] k;
        int hit;
        int slot;
        t_status st;
        k = rq.key & KEY_MASK;
        hit = -1;
        slot = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_key[i] == k) hit = i;
            if (!tbl_valid[i]) slot = i;
        end
        case (rq.req)
            REQ_ACQ_SHARED, REQ_ACQ_EXCL: begin
                if (hit < 0) begin
                    if (slot < 0) begin
                        st = STAT_FULL;
                    end else begin
                        tbl_valid[slot] = 1'b1;
                        tbl_key[slot]   = k;
                        tbl_excl[slot]  = (rq.req == REQ_ACQ_EXCL);
                        tbl_count[slot] = (rq.req == REQ_ACQ_SHARED) ? 1 : 0;
                        hit = slot;
                        st = STAT_GRANTED;
                    end
                end else if (rq.req == REQ_ACQ_SHARED) begin
                    if (tbl_excl[hit]) begin
                        st = STAT_CONFLICT;
                    end else if (tbl_count[hit] >= MAX_SHARED) begin
                        st = STAT_LIMIT;
                    end else begin
                        tbl_count[hit]++;
                        st = STAT_GRANTED;
                    end
                end else if (tbl_excl[hit] || tbl_count[hit] != 0) begin
                    st = STAT_CONFLICT;
                end else begin
                    tbl_excl[hit] = 1'b1;
                    st = STAT_GRANTED;
                end
            end
            REQ_REL_SHARED: begin
                if (hit < 0 || tbl_count[hit] == 0) begin
                    st = STAT_IGNORED;
                end else begin
                    tbl_count[hit]--;
                    st = STAT_RELEASED;
                end
            end
            default: begin
                if (hit < 0 || !tbl_excl[hit]) begin
                    st = STAT_IGNORED;
                end else begin
                    tbl_excl[hit] = 1'b0;
                    st = STAT_RELEASED;
                end
            end
        endcase
        // An entry with no holders left is freed.
        if (hit >= 0 && tbl_count[hit] == 0 && !tbl_excl[hit]) tbl_valid[hit] = 1'b0;
        res.status = st;
        if (hit >= 0 && tbl_valid[hit]) begin
            res.holders = 8'(tbl_count[hit]);
            res.excl    = tbl_excl[hit];
        end else begin
            res.holders = '0;
            res.excl    = 1'b0;
        end
    endtask

    task automatic queue_request(input t_req_type req, input logic [KEY_IN_W-1:0] key);
        t_lock_req rq;
        rq.req = req;
        rq.key = key;
        request_q.push_back(rq);
    endtask

    // Driver: presents the head of the request queue in bursts with random gaps.
    always @(posedge i_clk) begin : driver_blk
        t_lock_result res;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                update_lock_table(request_q[0], res);
                grant_q.push_back(res);
                void'(request_q.pop_front());
            end
            if (start && busy) begin
                // The word is still waiting to be taken; hold it.
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_q.size() > 0) begin
                start          <= 1'b1;
                i_req_type     <= request_q[0].req;
                i_resource_key <= request_q[0].key;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every result word is checked against the oldest expected one.
    always @(posedge i_clk) begin : monitor_blk
        t_lock_result want;
        if (i_rst_n && o_valid) begin
            if (grant_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Unexpected result word: status %0d holders %0d excl %0d",
                             o_status, o_holder_count, o_exclusive_held);
            end else begin
                want = grant_q.pop_front();
                if (o_status !== want.status || o_holder_count !== want.holders ||
                        o_exclusive_held !== want.excl) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"Result mismatch: expected status %0d holders %0d excl %0d,",
                                  " got status %0d holders %0d excl %0d"},
                                 want.status, want.holders, want.excl,
                                 o_status, o_holder_count, o_exclusive_held);
                end
            end
        end
    end

    // Watchdog: the run is stuck if no word moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [KEY_IN_W-1:0] fresh [TABLE_ENTRIES + 1];
        logic [KEY_IN_W-1:0] deep_key;
        int pick;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_excl[i]  = 1'b0;
            tbl_count[i] = 0;
            tbl_key[i]   = '0;
        end

        // Directed: releases with no hold, shared and exclusive conflicts,
        // freeing of entries and the extreme keys.
        queue_request(REQ_REL_SHARED, '0);
        queue_request(REQ_REL_EXCL,   '0);
        queue_request(REQ_ACQ_SHARED, '0);
        queue_request(REQ_ACQ_SHARED, '0);
        queue_request(REQ_ACQ_EXCL,   '0);
        queue_request(REQ_REL_EXCL,   '0);
        queue_request(REQ_ACQ_EXCL,   '1);
        queue_request(REQ_ACQ_SHARED, '1);
        queue_request(REQ_ACQ_EXCL,   '1);
        queue_request(REQ_REL_SHARED, '1);
        queue_request(REQ_REL_EXCL,   '1);
        queue_request(REQ_REL_EXCL,   '1);
        queue_request(REQ_REL_SHARED, '0);
        queue_request(REQ_REL_SHARED, '0);
        queue_request(REQ_REL_SHARED, '0);
        queue_request(REQ_ACQ_EXCL,   32'hAAAA_AAAA);
        queue_request(REQ_ACQ_SHARED, 32'h5555_5555);
        queue_request(REQ_ACQ_EXCL,   32'h5555_5555);
        queue_request(REQ_REL_EXCL,   32'hAAAA_AAAA);
        queue_request(REQ_REL_SHARED, 32'h5555_5555);

        // Fill the table past its size, then empty it again.
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            fresh[i] = $urandom;
            queue_request(($urandom_range(0, 1) == 0) ? REQ_ACQ_EXCL : REQ_ACQ_SHARED,
                          fresh[i]);
        end
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            queue_request(REQ_REL_EXCL, fresh[i]);
            queue_request(REQ_REL_SHARED, fresh[i]);
        end

        // Drive one key to the shared-holder limit and back down.
        deep_key = $urandom;
        for (int i = 0; i <= MAX_SHARED; i++) queue_request(REQ_ACQ_SHARED, deep_key);
        queue_request(REQ_ACQ_EXCL, deep_key);
        for (int i = 0; i <= MAX_SHARED; i++) queue_request(REQ_REL_SHARED, deep_key);

        // Random traffic over a small key pool, so that keys collide, holds
        // build up and are released, and the table fills now and then.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = $urandom;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                queue_request(t_req_type'($urandom_range(0, 3)), $urandom);
            else if (pick < 40)
                queue_request(REQ_ACQ_SHARED, key_pool[$urandom_range(0, POOL_KEYS - 1)]);
            else if (pick < 55)
                queue_request(REQ_ACQ_EXCL, key_pool[$urandom_range(0, POOL_KEYS - 1)]);
            else if (pick < 85)
                queue_request(REQ_REL_SHARED, key_pool[$urandom_range(0, POOL_KEYS - 1)]);
            else
                queue_request(REQ_REL_EXCL, key_pool[$urandom_range(0, POOL_KEYS - 1)]);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every result word to arrive.
        while (request_q.size() > 0 || start || grant_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0 && grant_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/selt_pkg.sv
hw/rtl/selt_ctrl.sv
hw/rtl/selt_datapath.sv
hw/rtl/shared_exclusive_lock_table.sv
dv/tb_shared_exclusive_lock_table.sv
